// ----- src/wbps_pkg.sv -----
// Package for the wildcard byte pattern scanner: sizes, register codes,
// the configuration bundle and pattern byte lookup helpers.
// Depends on nothing; every other source file imports it.
package wbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 28;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CFG_DATA_W  = 64;
  localparam int CARE_W      = 16;
  localparam int LEN_CFG_W   = 5;
  localparam int BYTE_W      = 8;
  localparam int BANK_BYTES  = 8;
  localparam int BANK_SEL_W  = $clog2(CFG_DATA_W);
  localparam int BANK_IDX_W  = $clog2(BANK_BYTES);
  localparam int CARE_IDX_W  = $clog2(CARE_W);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  typedef enum logic [1:0] {
    CFG_PAT_LO = 2'd0,
    CFG_PAT_HI = 2'd1,
    CFG_CARE   = 2'd2,
    CFG_LEN    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [CARE_W-1:0]     care;
    logic [LEN_CFG_W-1:0]  len;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] pattern_byte(cfg_t c, logic [LEN_W-1:0] k);
    logic [BYTE_W-1:0]     b;
    logic [BANK_SEL_W-1:0] lsb;
    lsb = BANK_SEL_W'(k[BANK_IDX_W-1:0]) * BANK_SEL_W'(BYTE_W);
    if (k < LEN_W'(BANK_BYTES)) begin
      b = c.pat_lo[lsb +: BYTE_W];
    end else if (k < LEN_W'(2 * BANK_BYTES)) begin
      b = c.pat_hi[lsb +: BYTE_W];
    end else begin
      b = '0;
    end
    return b;
  endfunction

  function automatic logic cares(cfg_t c, logic [LEN_W-1:0] k);
    logic r;
    if (k < LEN_W'(CARE_W)) begin
      r = c.care[k[CARE_IDX_W-1:0]];
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- src/wbps_in_if.sv -----
// Input channel of the scanner: one region byte and its end flag per word.
// Depends on wbps_pkg for the byte width.
interface wbps_in_if;
  import wbps_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] source_byte;
  logic              last_byte;

  modport source (output valid, output source_byte, output last_byte, input ready);
  modport sink   (input valid, input source_byte, input last_byte, output ready);
endinterface

// ----- src/wbps_out_if.sv -----
// Result channel of the scanner: match flag, match start offset, region end.
// Depends on wbps_pkg for the offset width.
interface wbps_out_if;
  import wbps_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [OFFSET_BITS-1:0] match_offset;
  logic                   region_done;

  modport source (output valid, output found, output match_offset, output region_done,
                  input ready);
  modport sink   (input valid, input found, input match_offset, input region_done,
                  output ready);
endinterface

// ----- src/wildcard_byte_pattern_scanner.sv -----
// Top level of the wildcard byte pattern scanner: a chain of window cells,
// match and overlap control, and the result register.
// Depends on wbps_pkg, wbps_in_if, wbps_out_if, wbps_cfg and wbps_cell.
//
//   Port     Dir  Contents
//   in_ch    in   source_byte, last_byte
//   out_ch   out  found, match_offset, region_done
//   cfg_*    in   write enable, register index, 64-bit write data
//
// One byte is taken every cycle while the input is not stalled; the cell chain
// compares the whole window in the cycle the byte arrives, and the result is in
// the output register in the next cycle. Bytes that end no match and do not end
// a region give no word. The input stalls only while a result waits in the output
// register and out_ch.ready is low. Reset is synchronous.
module wildcard_byte_pattern_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  wbps_in_if.sink                         in_ch,
  wbps_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  wbps_pkg::cfg_idx_t              cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wbps_pkg::*;

  cfg_t cfg;

  logic [BYTE_W-1:0]      chain [MAX_PATTERN+1];
  logic [BYTE_W-1:0]      pat_sel [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cmp_en;
  logic [MAX_PATTERN-1:0] hits;

  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W-1:0]       seen_r, seen_nxt;
  logic [LEN_W-1:0]       holdoff_r, holdoff_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic                   in_acc;
  logic                   found;
  logic [OFFSET_BITS-1:0] start;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [OFFSET_BITS-1:0] out_offset_r;
  logic                   out_done_r;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  always_comb begin
    if (cfg.len == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(cfg.len) > MAX_PATTERN) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(cfg.len);
    end
  end

  // Cell d sees the byte that arrived d words ago; it pairs with pattern
  // byte eff_len-1-d when it lies inside the active window.
  always_comb begin
    for (int d = 0; d < MAX_PATTERN; d++) begin
      logic [LEN_W-1:0] k;
      k = eff_len - LEN_W'(d) - LEN_W'(1);
      if (LEN_W'(d) < eff_len) begin
        pat_sel[d] = pattern_byte(cfg, k);
        cmp_en[d]  = cares(cfg, k);
      end else begin
        pat_sel[d] = '0;
        cmp_en[d]  = 1'b0;
      end
    end
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign chain[0] = in_ch.source_byte;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    wbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .byte_in  (chain[g]),
      .pat_byte (pat_sel[g]),
      .cmp_en   (cmp_en[g]),
      .byte_out (chain[g+1]),
      .hit      (hits[g])
    );
  end

  always_comb begin
    seen_nxt = (int'(seen_r) < MAX_PATTERN) ? seen_r + LEN_W'(1) : seen_r;
    found    = (holdoff_r == '0) && (seen_nxt >= eff_len) && (pos_r != OFFSET_MAX)
               && (&hits);
    start    = pos_r + OFFSET_BITS'(1) - OFFSET_BITS'(eff_len);
    if (holdoff_r != '0) begin
      holdoff_nxt = holdoff_r - LEN_W'(1);
    end else if (found) begin
      holdoff_nxt = eff_len - LEN_W'(1);
    end else begin
      holdoff_nxt = '0;
    end
    pos_nxt = (pos_r != OFFSET_MAX) ? pos_r + OFFSET_BITS'(1) : pos_r;
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      holdoff_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_ch.last_byte) begin
          seen_r    <= '0;
          holdoff_r <= '0;
          pos_r     <= '0;
        end else begin
          seen_r    <= seen_nxt;
          holdoff_r <= holdoff_nxt;
          pos_r     <= pos_nxt;
        end
        out_valid_r <= found || in_ch.last_byte;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_found_r  <= found;
      out_offset_r <= found ? start : '0;
      out_done_r   <= in_ch.last_byte;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.match_offset = out_offset_r;
  assign out_ch.region_done  = out_done_r;

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty output register");

  a_holdoff_range : assert property (@(posedge clk) disable iff (!rst_n)
    int'(holdoff_r) < MAX_PATTERN)
    else $error("overlap holdoff beyond pattern length");

  a_seen_range : assert property (@(posedge clk) disable iff (!rst_n)
    int'(seen_r) <= MAX_PATTERN)
    else $error("byte count beyond window size");

  a_region_clear : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_byte |=> seen_r == '0 && holdoff_r == '0 && pos_r == '0)
    else $error("region state not cleared after last byte");

  a_done_word : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_byte |=> out_valid_r && out_done_r)
    else $error("last byte gave no region end word");
endmodule

// ----- src/wbps_cfg.sv -----
// Configuration registers of the scanner, written through a plain write port.
// Depends on wbps_pkg for the register codes and the cfg_t bundle.
module wbps_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  wbps_pkg::cfg_idx_t             cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output wbps_pkg::cfg_t                 cfg
);
  import wbps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_lo <= '0;
      cfg_r.pat_hi <= '0;
      cfg_r.care   <= '1;
      cfg_r.len    <= LEN_CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LO: cfg_r.pat_lo <= cfg_wdata;
        CFG_PAT_HI: cfg_r.pat_hi <= cfg_wdata;
        CFG_CARE:   cfg_r.care   <= cfg_wdata[CARE_W-1:0];
        CFG_LEN:    cfg_r.len    <= cfg_wdata[LEN_CFG_W-1:0];
        default:    cfg_r.len    <= cfg_r.len;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

// ----- src/wbps_cell.sv -----
// One window cell: holds one region byte, passes it to the next cell on
// every accepted word and checks the incoming byte against its pattern byte.
// Depends on wbps_pkg for the byte width.
module wbps_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [wbps_pkg::BYTE_W-1:0] byte_in,
  input  logic [wbps_pkg::BYTE_W-1:0] pat_byte,
  input  logic                       cmp_en,
  output logic [wbps_pkg::BYTE_W-1:0] byte_out,
  output logic                       hit
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = !cmp_en || (byte_in == pat_byte);
endmodule
